// ----- rtl/core/tetra_barycentric_locate_macros.svh -----
// Assertion shorthands shared by the RTL that checks itself.
`ifndef TETRA_BARYCENTRIC_LOCATE_MACROS_SVH
`define TETRA_BARYCENTRIC_LOCATE_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define TBL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define TBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tbl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tbl_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int TOL_BITS = 28;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 28'd2684;

    localparam int LOC_BITS = 32;
    localparam logic [LOC_BITS-1:0] LOC_MAX = 32'h7FFF_FFFF;
    localparam logic [LOC_BITS-1:0] LOC_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_FLUSH,
        BK_DIV,
        BK_DONE
    } t_back_state;

    // multiply program segments: three cross products, each followed by its dots
    typedef enum logic [2:0] {
        SEG_X23,
        SEG_DOT_E1,
        SEG_DOT_R,
        SEG_X31,
        SEG_DOT_S,
        SEG_X12,
        SEG_DOT_T
    } t_seg;

    typedef struct packed {
        logic degenerate;
        logic in_tet;
    } t_flags;

endpackage
`default_nettype wire

// ----- rtl/core/tbl_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tbl_front #(
    parameter int CB = 24,
    parameter int DW = CB + 1
) (
    input  logic              i_clk,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_user,   // op, vertex_index
    input  logic [3*CB-1:0]   i_data,   // x, y, z
    input  logic              i_full,
    output logic              o_push,
    output logic [12*DW-1:0]  o_job     // e1, e2, e3, d; x,y,z each
);

    logic [CB-1:0] r_vtx [12];
    logic          accept;
    logic          op;
    logic [1:0]    vidx;

    assign op      = i_user[0];
    assign vidx    = i_user[2:1];
    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && (op == tbl_pkg::OP_QUERY);

    always_ff @(posedge i_clk) begin
        if (accept && (op == tbl_pkg::OP_LOAD)) begin
            for (int v = 0; v < 4; v++) begin
                if (vidx == 2'(v)) begin
                    for (int i = 0; i < 3; i++) begin
                        r_vtx[v*3+i] <= i_data[i*CB +: CB];
                    end
                end
            end
        end
    end

    // edge vectors from vertex 0, snapshot taken at accept
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                o_job[(k*3+i)*DW +: DW] = {r_vtx[(k+1)*3+i][CB-1], r_vtx[(k+1)*3+i]}
                                        - {r_vtx[i][CB-1], r_vtx[i]};
            end
            o_job[(9+i)*DW +: DW] = {i_data[i*CB+CB-1], i_data[i*CB +: CB]}
                                  - {r_vtx[i][CB-1], r_vtx[i]};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/tbl_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tbl_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/tbl_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tbl_div #(
    parameter int AW = 78,
    parameter int F  = 28
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [AW-1:0]               i_num,
    input  logic signed [AW-1:0]               i_den,
    output logic                               o_done,
    output logic [tbl_pkg::LOC_BITS-1:0]       o_quo
);

    localparam int QB  = tbl_pkg::LOC_BITS;
    localparam int DVW = AW + QB;
    localparam int CNW = $clog2(QB);

    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_dsh;
    logic [QB-1:0]  r_q;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic           r_neg;

    logic [AW-1:0]  num_mag;
    logic [AW-1:0]  den_mag;
    logic [DVW-1:0] diff;
    logic           ge;
    logic [QB-1:0]  mag;
    logic           sat;

    assign num_mag = i_num[AW-1] ? AW'(-i_num) : AW'(i_num);
    assign den_mag = i_den[AW-1] ? AW'(-i_den) : AW'(i_den);
    assign diff    = r_rem - r_dsh;
    assign ge      = (r_rem >= r_dsh);

    // top quotient bit set means the magnitude reached 2^31: saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= DVW'(num_mag) << F;
                r_dsh  <= DVW'(den_mag) << (QB - 1);
                r_q    <= '0;
                r_cnt  <= CNW'(QB - 1);
                r_busy <= 1'b1;
                r_neg  <= i_num[AW-1] ^ i_den[AW-1];
            end else if (r_busy) begin
                if (ge) r_rem <= diff;
                r_q   <= {r_q[QB-2:0], ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign sat    = r_q[QB-1];
    assign mag    = {1'b0, r_q[QB-2:0]};
    assign o_done = r_done;
    assign o_quo  = r_neg ? (sat ? tbl_pkg::LOC_MIN : QB'(-mag))
                          : (sat ? tbl_pkg::LOC_MAX : mag);

endmodule
`default_nettype wire

// ----- rtl/core/tbl_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tbl_back #(
    parameter int CB = 24,
    parameter int F  = 28,
    parameter int DW = CB + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  logic [12*DW-1:0]              i_job,
    output logic                          o_pop,
    input  logic [tbl_pkg::TOL_BITS-1:0]  i_tol,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [3*tbl_pkg::LOC_BITS-1:0] o_res_data,
    output tbl_pkg::t_flags               o_res_flags
);

    localparam int CW = 2 * DW + 1;
    localparam int PW = 2 * DW + 1;
    localparam int AW = 3 * DW + 3;
    localparam int JW = 12 * DW;
    localparam int QB = tbl_pkg::LOC_BITS;
    localparam int TW = QB + 4;
    localparam logic signed [TW-1:0] ONE_Q = TW'(1) <<< F;

    tbl_pkg::t_back_state r_state, n_state;
    tbl_pkg::t_seg        r_seg, r_pseg;

    logic [JW-1:0]          r_job;
    logic [1:0]             r_j, r_pj;
    logic                   r_t, r_pt, r_pv, r_pdot;
    logic signed [CW-1:0]   r_c [3];
    logic signed [PW-1:0]   r_prod;
    logic signed [AW-1:0]   r_acc, r_den;
    logic signed [AW-1:0]   r_num [3];
    logic [1:0]             r_k;
    logic [QB-1:0]          r_loc [3];
    logic                   r_deg;

    logic                   issue, last_issue, div_start, div_done;
    logic [QB-1:0]          div_quo;
    logic [1:0]             div_sel;
    logic signed [AW-1:0]   div_num;
    logic [1:0]             ka, kb, i1, i2;
    logic                   is_dot;
    logic [3:0]             xl, yl;
    logic signed [DW-1:0]   x_op, y_lane;
    logic signed [DW:0]     y_op;
    logic signed [AW-1:0]   term, acc_sum;
    logic                   in_tet;
    logic signed [TW-1:0]   tolx, lim, sum, lv;

    // ---- operand selection ----
    always_comb begin
        case (r_seg)
            tbl_pkg::SEG_X23:    begin ka = 2'd1; kb = 2'd2; is_dot = 1'b0; end
            tbl_pkg::SEG_DOT_E1: begin ka = 2'd0; kb = 2'd0; is_dot = 1'b1; end
            tbl_pkg::SEG_X31:    begin ka = 2'd2; kb = 2'd0; is_dot = 1'b0; end
            tbl_pkg::SEG_X12:    begin ka = 2'd0; kb = 2'd1; is_dot = 1'b0; end
            default:             begin ka = 2'd3; kb = 2'd0; is_dot = 1'b1; end
        endcase
        case (r_j)
            2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
            2'd2:    begin i1 = 2'd0; i2 = 2'd1; end
            default: begin i1 = 2'd1; i2 = 2'd2; end
        endcase
        if (is_dot) begin
            xl = 4'(ka) * 4'd3 + 4'(r_j);
            yl = 4'd0;
        end else if (!r_t) begin
            xl = 4'(ka) * 4'd3 + 4'(i1);
            yl = 4'(kb) * 4'd3 + 4'(i2);
        end else begin
            xl = 4'(ka) * 4'd3 + 4'(i2);
            yl = 4'(kb) * 4'd3 + 4'(i1);
        end
        x_op   = r_job[xl*DW +: DW];
        y_lane = r_job[yl*DW +: DW];
        if (!is_dot) begin
            y_op = {y_lane[DW-1], y_lane};
        end else if (r_t) begin
            y_op = r_c[r_j][CW-1:DW];
        end else begin
            y_op = {1'b0, r_c[r_j][DW-1:0]};
        end
    end

    // ---- accumulate stage ----
    always_comb begin
        term = AW'(r_prod);
        if (r_pt) term = term <<< DW;
        acc_sum = ((r_pj == 2'd0) && !r_pt) ? term : r_acc + term;
    end

    // ---- divider ----
    assign div_sel = (r_state == tbl_pkg::BK_FLUSH) ? 2'd0 : r_k + 2'd1;
    always_comb begin
        case (div_sel)
            2'd0:    div_num = r_num[0];
            2'd1:    div_num = r_num[1];
            default: div_num = r_num[2];
        endcase
    end

    tbl_div #(.AW(AW), .F(F)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ---- control ----
    assign last_issue = (r_seg == tbl_pkg::SEG_DOT_T) && (r_j == 2'd2) && r_t;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tbl_pkg::BK_IDLE:  if (i_job_valid) n_state = tbl_pkg::BK_MUL;
            tbl_pkg::BK_MUL:   if (last_issue) n_state = tbl_pkg::BK_FLUSH;
            tbl_pkg::BK_FLUSH: n_state = (r_den == '0) ? tbl_pkg::BK_DONE : tbl_pkg::BK_DIV;
            tbl_pkg::BK_DIV:   if (div_done && (r_k == 2'd2)) n_state = tbl_pkg::BK_DONE;
            tbl_pkg::BK_DONE:  if (i_res_ready) n_state = tbl_pkg::BK_IDLE;
            default:           n_state = tbl_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        issue       = 1'b0;
        div_start   = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            tbl_pkg::BK_IDLE:  o_pop = i_job_valid;
            tbl_pkg::BK_MUL:   issue = 1'b1;
            tbl_pkg::BK_FLUSH: div_start = (r_den != '0);
            tbl_pkg::BK_DIV:   div_start = div_done && (r_k != 2'd2);
            tbl_pkg::BK_DONE:  o_res_valid = 1'b1;
            default:           o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbl_pkg::BK_IDLE;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_seg <= tbl_pkg::SEG_X23;
            r_j   <= 2'd0;
            r_t   <= 1'b0;
        end
        if (issue) begin
            r_prod <= x_op * y_op;
            r_pdot <= is_dot;
            r_pseg <= r_seg;
            r_pj   <= r_j;
            r_pt   <= r_t;
            r_t    <= ~r_t;
            if (r_t) begin
                if (r_j == 2'd2) begin
                    r_j   <= 2'd0;
                    r_seg <= tbl_pkg::t_seg'(3'(r_seg) + 3'd1);
                end else begin
                    r_j <= r_j + 2'd1;
                end
            end
        end
        if (r_pv) begin
            if (!r_pdot) begin
                r_c[r_pj] <= r_pt ? r_c[r_pj] - r_prod : r_prod;
            end else begin
                r_acc <= acc_sum;
                if ((r_pj == 2'd2) && r_pt) begin
                    case (r_pseg)
                        tbl_pkg::SEG_DOT_E1: r_den    <= acc_sum;
                        tbl_pkg::SEG_DOT_R:  r_num[0] <= acc_sum;
                        tbl_pkg::SEG_DOT_S:  r_num[1] <= acc_sum;
                        default:             r_num[2] <= acc_sum;
                    endcase
                end
            end
        end
        if (r_state == tbl_pkg::BK_FLUSH) begin
            r_k   <= 2'd0;
            r_deg <= (r_den == '0);
            for (int i = 0; i < 3; i++) r_loc[i] <= '0;
        end
        if ((r_state == tbl_pkg::BK_DIV) && div_done) begin
            r_loc[r_k] <= div_quo;
            r_k        <= r_k + 2'd1;
        end
    end

    // ---- inside test on the saturated coordinates ----
    always_comb begin
        tolx   = TW'(i_tol);
        lim    = ONE_Q + tolx;
        sum    = '0;
        in_tet = !r_deg;
        for (int i = 0; i < 3; i++) begin
            lv  = TW'($signed(r_loc[i]));
            sum = sum + lv;
            if ((lv < -tolx) || (lv > lim)) in_tet = 1'b0;
        end
        if (sum > lim) in_tet = 1'b0;
    end

    assign o_res_data             = {r_loc[2], r_loc[1], r_loc[0]};
    assign o_res_flags.degenerate = r_deg;
    assign o_res_flags.in_tet     = in_tet;

endmodule
`default_nettype wire

// ----- rtl/core/tetra_barycentric_locate.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Point location in a tetrahedron by local (barycentric) coordinates.
// s_axis carries items: tuser[0] = op (0 load vertex, 1 query), tuser[2:1] =
// vertex index, tdata = x, y, z (signed Q12.12). A load writes one vertex
// and gives no result; all four must be loaded before the first query.
// Each query gives one m_axis item: tdata = r, s, t (signed Q4.28,
// saturating), tuser = inside, degenerate.
// The cfg channel writes the inside-test tolerance; it is taken at any
// time, but should only change while no query is in flight.
// A query runs first on the single shared multiplier (three cross
// products and four dot products), then through three radix-2
// divisions. A degenerate element skips the divisions. The back end
// takes a new query only after its last result has been handed on. A
// two-entry queue between front and back keeps s_axis open while the
// back end works, until the queue is full.
// Reset clears the control state and sets tolerance to 2684; vertices are
// undefined until loaded. A stalled m_axis holds its item; the back end
// stops after its next result and then the queue fills up.
`include "tetra_barycentric_locate_macros.svh"
module tetra_barycentric_locate #(
    parameter int COORD_BITS      = 24,
    parameter int LOCAL_FRAC_BITS = 28
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,  // coord_x, coord_y, coord_z
    input  logic [2:0]                           s_axis_tuser,  // op, vertex_index
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [3*tbl_pkg::LOC_BITS-1:0]       m_axis_tdata,  // local_r, local_s, local_t
    output logic [1:0]                           m_axis_tuser,  // inside_res, degenerate
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tbl_pkg::TOL_BITS-1:0]         i_cfg_data
);

    localparam int DW = COORD_BITS + 1;
    localparam int JW = 12 * DW;

    logic                            w_push, w_full, w_pop, w_job_valid;
    logic [JW-1:0]                   w_job_in, w_job_out;
    logic                            w_res_valid, w_res_ready;
    logic [3*tbl_pkg::LOC_BITS-1:0]  w_res_data;
    tbl_pkg::t_flags                 w_res_flags;

    logic [tbl_pkg::TOL_BITS-1:0]    r_tol;
    logic                            r_out_valid;
    logic [3*tbl_pkg::LOC_BITS-1:0]  r_out_data;
    tbl_pkg::t_flags                 r_out_user;

    tbl_front #(.CB(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_user  (s_axis_tuser),
        .i_data  (s_axis_tdata[3*COORD_BITS-1:0]),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    tbl_queue #(.W(JW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_data  (w_job_out)
    );

    tbl_back #(.CB(COORD_BITS), .F(LOCAL_FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .i_tol       (r_tol),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res_data  (w_res_data),
        .o_res_flags (w_res_flags)
    );

    assign o_cfg_ready = 1'b1;
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= tbl_pkg::TOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_tol <= i_cfg_data;
            if (w_res_ready) r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out_data <= w_res_data;
            r_out_user <= w_res_flags;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `TBL_ASSERT_IMPL(a_deg_clean, i_clk, i_rst_n, r_out_valid && r_out_user.degenerate, (r_out_data == '0) && !r_out_user.in_tet, "degenerate item with nonzero coordinates or inside set")
    `TBL_ASSERT_NEXT(a_res_lands, i_clk, i_rst_n, w_res_valid && w_res_ready, r_out_valid, "finished item not registered at output")
    `TBL_ASSERT_IMPL(a_pop_valid, i_clk, i_rst_n, w_pop, w_job_valid && !w_res_valid, "back end took a query from an empty queue")

endmodule
`default_nettype wire
